// File: rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; every other file of the block imports this package.
package bba_pkg;

  localparam int unsigned BlockIdW = 11;
  localparam int unsigned GrantW   = 10;
  localparam int unsigned WordW    = 32;
  localparam int unsigned BitIdxW  = 5;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic                func;
    logic [BlockIdW-1:0] block_id;
  } in_t;

  typedef struct packed {
    logic [GrantW-1:0] granted_block;
    logic [1:0]        status;
  } out_t;

  // Classified request: the offset is only meaningful for a free.
  typedef struct packed {
    cmd_kind_e           kind;
    logic [BlockIdW-1:0] offset;
  } cmd_t;

endpackage

// File: rtl/bitmap_block_allocator_top.sv
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_front, bba_cmd_fifo and bba_back.
//
// Usage: requests arrive as valid/ready transactions on in_*; each carries
// func (alloc or free) and block_id. Every request yields exactly one
// response transaction on out_* with granted_block and status, in request
// order. data_start is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, which the block itself does not enforce.
// Flow: the engine takes each request from the command queue, does its work,
// then loads the output register. An alloc scans one 32-bit bitmap word per
// cycle through the single read port of the bitmap memory and stops early
// once it finds a free block. A free reads and writes back one word, and an
// out-of-range free goes straight to the response. The engine works on one
// request at a time and takes the next only once the last response has been
// loaded into the output register.
// Reset: the bitmap is swept to all free, one word per cycle; in_ready_o stays
// low meanwhile, while configuration writes are taken as usual.
// Stall: while out_ready_i is low the finished response waits in the output
// register; the engine finishes one more request and holds it, and the queue
// takes two more before in_ready_o falls.
module bitmap_block_allocator_top import bba_pkg::*; #(
  parameter int unsigned TOTAL_BLOCKS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BlockIdW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  logic [BlockIdW-1:0] data_start_q;
  cmd_t                front_cmd;
  cmd_t                q_cmd;
  logic                push_ready, q_valid, q_ready, clr_busy;

  // The single configuration register: block number of the first data block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= '0;
    end else if (cfg_we_i) begin
      data_start_q <= cfg_wdata_i;
    end
  end

  // Requests are held off until the bitmap has been cleared.
  assign in_ready_o = push_ready && !clr_busy;

  bba_front #(
    .TOTAL_BLOCKS(TOTAL_BLOCKS)
  ) u_front (
    .data_start_i(data_start_q),
    .in_data_i   (in_data_i),
    .cmd_o       (front_cmd)
  );

  bba_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i && !clr_busy),
    .push_ready_o(push_ready),
    .push_data_i (front_cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_cmd)
  );

  bba_back #(
    .TOTAL_BLOCKS(TOTAL_BLOCKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_start_i(data_start_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/bba_front.sv
// Front end of the allocator: classifies each request and range-checks frees.
// Depends on bba_pkg.
module bba_front import bba_pkg::*; #(
  parameter int unsigned TOTAL_BLOCKS = 1024
) (
  input  logic [BlockIdW-1:0] data_start_i,
  input  in_t                 in_data_i,
  output cmd_t                cmd_o
);

  localparam int unsigned LimW = $clog2(TOTAL_BLOCKS + 1);
  localparam int unsigned CmpW = (LimW > BlockIdW) ? LimW : BlockIdW;

  logic in_range;

  // A block can be freed only between the data start and the block count.
  assign in_range = (in_data_i.block_id >= data_start_i) &&
                    (CmpW'(in_data_i.block_id) < CmpW'(TOTAL_BLOCKS));

  always_comb begin
    cmd_o.offset = in_data_i.block_id - data_start_i;
    if (in_data_i.func == FUNC_ALLOC) begin
      cmd_o.kind = CMD_ALLOC;
    end else if (in_range) begin
      cmd_o.kind = CMD_FREE;
    end else begin
      cmd_o.kind = CMD_REJECT;
    end
  end

endmodule

// File: rtl/bba_cmd_fifo.sv
// Two-entry command queue between the front end and the bitmap engine.
// Depends on bba_pkg.
module bba_cmd_fifo import bba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/bba_back.sv
// Bitmap engine: word-wide bitmap memory, clearing pass, first-fit scan,
// free write-back and the output register. Depends on bba_pkg.
module bba_back import bba_pkg::*; #(
  parameter int unsigned TOTAL_BLOCKS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BlockIdW-1:0] data_start_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  cmd_t                cmd_i,
  output logic                clr_busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  localparam int unsigned NWords = (TOTAL_BLOCKS + WordW - 1) / WordW;
  localparam int unsigned WW     = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int unsigned LimW   = $clog2(TOTAL_BLOCKS + 1);
  localparam int unsigned CmpW   = (LimW > BlockIdW) ? LimW : BlockIdW;
  localparam int unsigned OffW   = (WW + BitIdxW > BlockIdW) ? WW + BitIdxW : BlockIdW;
  localparam int unsigned XW     = ((LimW > WW + BitIdxW) ? LimW : WW + BitIdxW) + 1;
  localparam int unsigned SumW   = OffW + 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  function automatic logic [BitIdxW-1:0] lowest_zero(input logic [WordW-1:0] w);
    logic [BitIdxW-1:0] pos;
    pos = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BitIdxW'(i);
      end
    end
    return pos;
  endfunction

  logic [WordW-1:0]   mem [NWords];
  logic [WordW-1:0]   rdata_q;
  logic               mem_we;
  logic [WW-1:0]      mem_waddr, mem_raddr;
  logic [WordW-1:0]   mem_wdata;

  state_e             state_q, state_d;
  logic [WW-1:0]      clr_q, clr_d;
  logic [WW-1:0]      chk_w_q, chk_w_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic [LimW-1:0]    limit_q, limit_d;
  out_t               res_q, res_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_data_q, out_data_d;

  logic [OffW-1:0]    free_off;
  logic [XW-1:0]      lim_x, base_x;
  logic [WordW-1:0]   vmask, masked;
  logic               all_valid, none_valid, last_word, hit;
  logic [BitIdxW-1:0] hit_pos;
  logic [SumW-1:0]    grant_sum;

  // Number of offsets that exist, registered to keep the scan path short.
  assign limit_d = (CmpW'(data_start_i) < CmpW'(TOTAL_BLOCKS)) ?
                   LimW'(CmpW'(TOTAL_BLOCKS) - CmpW'(data_start_i)) : '0;

  assign free_off   = OffW'(cmd_i.offset);
  assign lim_x      = XW'(limit_q);
  assign base_x     = XW'({chk_w_q, {BitIdxW{1'b0}}});
  assign all_valid  = (base_x + XW'(WordW)) <= lim_x;
  assign none_valid = base_x >= lim_x;
  assign last_word  = (chk_w_q == WW'(NWords - 1)) || ((base_x + XW'(WordW)) >= lim_x);

  // Offsets past the limit look used, so the scan never grants them.
  always_comb begin
    if (all_valid) begin
      vmask = '1;
    end else if (none_valid) begin
      vmask = '0;
    end else begin
      vmask = (WordW'(1) << lim_x[BitIdxW-1:0]) - WordW'(1);
    end
  end

  assign masked    = rdata_q | ~vmask;
  assign hit       = ~&masked;
  assign hit_pos   = lowest_zero(masked);
  assign grant_sum = SumW'(data_start_i) + SumW'({chk_w_q, hit_pos});

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    chk_w_d     = chk_w_q;
    bit_d       = bit_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = chk_w_q;
    mem_wdata   = rdata_q;
    mem_raddr   = WW'(chk_w_q + WW'(1));

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = WW'(clr_q + WW'(1));
        if (clr_q == WW'(NWords - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_ready_o = cmd_valid_i;
        mem_raddr   = '0;
        chk_w_d     = '0;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_ALLOC: begin
              state_d = S_SCAN;
            end
            CMD_FREE: begin
              mem_raddr = free_off[WW+BitIdxW-1:BitIdxW];
              chk_w_d   = free_off[WW+BitIdxW-1:BitIdxW];
              bit_d     = free_off[BitIdxW-1:0];
              state_d   = S_FREE;
            end
            default: begin
              res_d   = '{granted_block: '0, status: ST_RANGE};
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // One word arrives per cycle while the next address is issued.
        chk_w_d = WW'(chk_w_q + WW'(1));
        if (hit) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q | (WordW'(1) << hit_pos);
          res_d     = '{granted_block: grant_sum[GrantW-1:0], status: ST_OK};
          state_d   = S_RESP;
        end else if (last_word) begin
          res_d   = '{granted_block: '0, status: ST_NO_FREE};
          state_d = S_RESP;
        end
      end
      S_FREE: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q & ~(WordW'(1) << bit_q);
        res_d     = '{granted_block: '0, status: ST_OK};
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      chk_w_q     <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      chk_w_q     <= chk_w_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q      <= bit_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign clr_busy_o  = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: test/bitmap_block_allocator_top_test.sv
// Self-checking testbench for bitmap_block_allocator_top: first-fit allocation and frees
// under random handshakes. Depends on bba_pkg and the allocator RTL; needs no other file.
`timescale 1ns / 100ps

// Keeps a private copy of the used bitmap and of the data start register and
// works out the response for every request the block takes.
class alloc_scoreboard #(int unsigned Blocks = 1024);
  bit                             used_map [Blocks];
  logic [bba_pkg::BlockIdW-1:0]   data_start;
  bba_pkg::out_t                  expected_q [$];
  int unsigned                    errors;
  int unsigned                    requests;
  int unsigned                    grants;
  int unsigned                    exhausted;
  int unsigned                    rejected;

  function new();
    foreach (used_map[i]) used_map[i] = 1'b0;
    data_start = '0;
    errors     = 0;
    requests   = 0;
    grants     = 0;
    exhausted  = 0;
    rejected   = 0;
  endfunction

  function void set_start(logic [bba_pkg::BlockIdW-1:0] value);
    data_start = value;
  endfunction

  function int unsigned outstanding();
    return expected_q.size();
  endfunction

  // Works out the response to one accepted request and queues it.
  function void note_request(bba_pkg::in_t req);
    bba_pkg::out_t resp;
    int unsigned   off;
    bit            found;
    resp        = '0;
    resp.status = bba_pkg::ST_OK;
    found       = 1'b0;
    requests++;
    if (req.func == bba_pkg::FUNC_ALLOC) begin
      // First fit: lowest offset whose block number still lies below the block count.
      for (off = 0; off < Blocks && off + int'(data_start) < Blocks && !found; off++) begin
        if (!used_map[off]) begin
          used_map[off]      = 1'b1;
          resp.granted_block = bba_pkg::GrantW'(off + int'(data_start));
          found              = 1'b1;
        end
      end
      if (found) begin
        grants++;
      end else begin
        resp.status = bba_pkg::ST_NO_FREE;
        exhausted++;
      end
    end else begin
      if (req.block_id < data_start || int'(req.block_id) >= Blocks) begin
        resp.status = bba_pkg::ST_RANGE;
        rejected++;
      end else begin
        used_map[req.block_id - data_start] = 1'b0;
      end
    end
    expected_q.push_back(resp);
  endfunction

  function void check_response(bba_pkg::out_t got);
    bba_pkg::out_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: response with nothing outstanding: granted %0d status %0d",
               $time, got.granted_block, got.status);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.granted_block !== want.granted_block) begin
      $display("%0t: granted_block mismatch: expected %0d, actual %0d",
               $time, want.granted_block, got.granted_block);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d",
               $time, want.status, got.status);
      errors++;
    end
  endfunction
endclass

module bitmap_block_allocator_top_test import bba_pkg::*; ();

  localparam int unsigned TotalBlocks   = 1024;
  // An alloc may scan every bitmap word, so this many cycles covers any request
  // still inside the engine once its response has gone.
  localparam int unsigned DrainCycles   = 40;
  // Longest stretch with no transaction on either side before the run is abandoned.
  localparam int unsigned WatchdogLimit = 3000;
  // Length of the one long hold-off on the response side.
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned HoldAtResp    = 150;
  localparam int unsigned RandPhases    = 9;
  localparam int unsigned PhaseItems    = 100;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [BlockIdW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;

  alloc_scoreboard #(TotalBlocks) sb;

  logic [BlockIdW-1:0] cur_start;
  int unsigned         start_writes;
  int unsigned         resp_seen;
  int unsigned         quiet_cycles = 0;

  bitmap_block_allocator_top #(
    .TOTAL_BLOCKS(TotalBlocks)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // All inputs of the block change only at rising edges, and its outputs only
  // follow rising edges, so the values seen at the falling edge are exactly the
  // ones the next rising edge will act on. Sampling there keeps the monitor free
  // of any ordering race within a time step. This one process notes requests,
  // checks responses and runs the watchdog.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_response(out_data_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d responses outstanding",
                 $time, WatchdogLimit, sb.outstanding());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offers one request. A gap lowers valid first; with no gap valid simply stays
  // high from the previous transaction, so it is never dropped and raised in the
  // same time step. Returns in the step of the edge that accepts the request.
  task automatic send_request(input in_t req, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // Writes data_start once the block has answered everything and had time to
  // finish any work still in flight. The scoreboard follows at the same edge.
  task automatic write_data_start(input logic [BlockIdW-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_start(value);
    cur_start = value;
    start_writes++;
  endtask

  function automatic in_t make_request(input logic func, input int unsigned id);
    in_t req;
    req.func     = func;
    req.block_id = BlockIdW'(id);
    return req;
  endfunction

  // Random traffic is mostly allocations and frees of blocks near the start of
  // the data area, where first fit keeps the used blocks, so frees usually hit
  // live allocations. The rest probes the range check and random block numbers.
  function automatic in_t random_request(input logic [BlockIdW-1:0] start);
    in_t         req;
    int unsigned pick;
    req.block_id = BlockIdW'($urandom_range(0, 2047));
    pick         = $urandom_range(0, 99);
    if (pick < 55) begin
      req.func = FUNC_ALLOC;
    end else begin
      req.func = FUNC_FREE;
      if (pick < 85) begin
        req.block_id = start + BlockIdW'($urandom_range(0, 255));
      end else if (pick < 93) begin
        case ($urandom_range(0, 3))
          0: req.block_id = start - 1'b1;
          1: req.block_id = BlockIdW'(TotalBlocks - 1);
          2: req.block_id = BlockIdW'(TotalBlocks);
          default: req.block_id = '1;
        endcase
      end
    end
    return req;
  endfunction

  // Each random phase runs under its own data start, covering zero, the top
  // data block, values past the block count and random settings.
  function automatic logic [BlockIdW-1:0] phase_start(input int unsigned phase);
    case (phase)
      0: return '0;
      1: return BlockIdW'(1000);
      2: return BlockIdW'($urandom_range(1, TotalBlocks - 1));
      3: return BlockIdW'(TotalBlocks - 1);
      4: return BlockIdW'(1016);
      5: return BlockIdW'($urandom_range(TotalBlocks, 2047));
      6: return BlockIdW'($urandom_range(0, 63));
      7: return '1;
      default: return '0;
    endcase
  endfunction

  // Response side: a random stall before each transaction, with runs of
  // responses taken back to back, and one long hold-off during which the sender
  // keeps offering requests until the queue fills and the input stalls.
  initial begin
    int unsigned gap;
    bit          held;
    held        = 1'b0;
    resp_seen   = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = ((resp_seen / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
      if (resp_seen == HoldAtResp && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      @(posedge clk_i);
      resp_seen++;
    end
  end

  initial begin
    in_t         req;
    int unsigned gap;
    sb           = new();
    cur_start    = '0;
    start_writes = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, data start zero: grants from the bottom, reuse of a freed
    // block, frees past the block count, a free of a block already free, and an
    // alloc whose ignored block id has every bit set.
    write_data_start('0);
    send_request(make_request(FUNC_ALLOC, 0), 0);
    send_request(make_request(FUNC_ALLOC, 0), 0);
    send_request(make_request(FUNC_ALLOC, 0), 1);
    send_request(make_request(FUNC_FREE, 1), 0);
    send_request(make_request(FUNC_ALLOC, 0), 0);
    send_request(make_request(FUNC_FREE, 2047), 2);
    send_request(make_request(FUNC_FREE, TotalBlocks), 0);
    send_request(make_request(FUNC_FREE, TotalBlocks - 1), 0);
    send_request(make_request(FUNC_FREE, 0), 0);
    send_request(make_request(FUNC_ALLOC, 2047), 0);

    // Only four offsets exist near the top: the map runs out, a free just below
    // the data start is rejected, and a freed top block is granted again.
    write_data_start(BlockIdW'(1020));
    send_request(make_request(FUNC_ALLOC, 0), 0);
    send_request(make_request(FUNC_ALLOC, 0), 0);
    send_request(make_request(FUNC_ALLOC, 0), 0);
    send_request(make_request(FUNC_ALLOC, 0), 3);
    send_request(make_request(FUNC_FREE, 1019), 0);
    send_request(make_request(FUNC_FREE, 1022), 0);
    send_request(make_request(FUNC_ALLOC, 0), 0);

    // Data start at and beyond the block count: no offsets at all.
    write_data_start(BlockIdW'(TotalBlocks));
    send_request(make_request(FUNC_ALLOC, 0), 0);
    send_request(make_request(FUNC_FREE, TotalBlocks), 0);
    write_data_start('1);
    send_request(make_request(FUNC_ALLOC, 0), 0);
    send_request(make_request(FUNC_FREE, 2047), 0);
    send_request(make_request(FUNC_FREE, 0), 0);

    // Random part. Every third phase the sender offers requests back to back.
    for (int unsigned phase = 0; phase < RandPhases; phase++) begin
      write_data_start(phase_start(phase));
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        req = random_request(cur_start);
        gap = (phase % 3 == 1) ? 0 : $urandom_range(0, 5);
        send_request(req, gap);
      end
    end
    in_valid_i <= 1'b0;

    // Let every response come back, then give the block time to show any
    // response that should not exist.
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests over %0d data start settings: %0d grants,",
             sb.requests, start_writes, sb.grants);
    $display("%0d allocs on a full map, %0d rejected frees, %0d mismatches.",
             sb.exhausted, sb.rejected, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
